[hdl/gta_pkg.sv]
// Shared types, codes and field arithmetic for the GHASH tag accumulator.
`default_nettype none

package gta_pkg;

  // Width of one GF(2^128) element and of the halves it travels in.
  localparam int BLOCK_BITS = 128;
  localparam int HALF_BITS = 64;
  localparam int BYTES_PER_BLOCK = BLOCK_BITS / 8;
  localparam int BYTE_COUNT_W = 5;
  localparam int REG_INDEX_W = 2;
  localparam int DIGIT_BITS_DEFAULT = 4;

  // Reduction constant for x^128 + x^7 + x^2 + x + 1 in GCM bit order.
  localparam logic [BLOCK_BITS-1:0] REDUCE_POLY = {8'he1, 120'd0};

  // Item codes.
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_INDEX_W-1:0] REG_KEY_FIRST = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_KEY_SECOND = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new item and start a multiply
    logic step;    // one digit step of the multiply
    logic commit;  // write the product back to the accumulator
    logic emit;    // present the tag and clear the accumulator
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_empty;  // offered item is an absorb with no valid bytes
    logic finish;      // item at work is a finish item
    logic out_busy;    // tag register holds a result not yet taken
  } status_t;

  // Multiply a field element by x: one step towards higher degree.
  function automatic logic [BLOCK_BITS-1:0] times_x(input logic [BLOCK_BITS-1:0] a);
    logic [BLOCK_BITS-1:0] r;
    r = a >> 1;
    if (a[0]) begin
      r = r ^ REDUCE_POLY;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/gta_ctrl.sv]
// Sequencer for the GHASH tag accumulator: item intake, digit steps and tag hand-off.
`default_nettype none

module gta_ctrl
  import gta_pkg::*;
#(
  parameter int STEPS = BLOCK_BITS / DIGIT_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // An empty absorb item is taken and dropped without touching the state.
        if (in_valid && !status.item_empty) begin
          cmd.load = 1'b1;
          count_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (count == LAST_STEP) begin
          cmd.commit = 1'b1;
          state_next = status.finish ? ST_EMIT : ST_IDLE;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/gta_datapath.sv]
// Datapath of the GHASH tag accumulator: key, accumulator, digit-serial multiplier and tag.
`default_nettype none

module gta_datapath
  import gta_pkg::*;
#(
  parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [REG_INDEX_W-1:0]  cfg_index,
  input  wire logic [HALF_BITS-1:0]    cfg_data,
  input  wire logic                    mode,
  input  wire logic [HALF_BITS-1:0]    block_first,
  input  wire logic [HALF_BITS-1:0]    block_second,
  input  wire logic [BYTE_COUNT_W-1:0] byte_count,
  input  wire logic [HALF_BITS-1:0]    mask_first,
  input  wire logic [HALF_BITS-1:0]    mask_second,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [HALF_BITS-1:0]         tag_first,
  output logic [HALF_BITS-1:0]         tag_second
);

  localparam int STEPS = (BLOCK_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int XP_W = STEPS * DIGIT_BITS;
  localparam int PAD = XP_W - BLOCK_BITS;

  logic [HALF_BITS-1:0] key_first, key_second;
  logic [BLOCK_BITS-1:0] acc;
  logic [BLOCK_BITS-1:0] prod;
  logic [XP_W-1:0] operand;
  logic item_finish;
  logic [BLOCK_BITS-1:0] mask;

  logic [BLOCK_BITS-1:0] key_pow [DIGIT_BITS];
  logic [BLOCK_BITS-1:0] prod_shift [DIGIT_BITS+1];
  logic [BLOCK_BITS-1:0] prod_next;
  logic [BLOCK_BITS-1:0] block_in;
  logic [BLOCK_BITS-1:0] byte_keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first <= '0;
      key_second <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_KEY_FIRST) begin
        key_first <= cfg_data;
      end else if (cfg_index == REG_KEY_SECOND) begin
        key_second <= cfg_data;
      end
    end
  end

  // H times x^k for each bit position of a digit.
  always_comb begin
    key_pow[0] = {key_first, key_second};
    for (int k = 1; k < DIGIT_BITS; k++) begin
      key_pow[k] = times_x(key_pow[k-1]);
    end
  end

  // Bytes at or past the byte count read as zero on an absorb item.
  always_comb begin
    for (int b = 0; b < BYTES_PER_BLOCK; b++) begin
      byte_keep[BLOCK_BITS-1-8*b -: 8] = (byte_count > BYTE_COUNT_W'(b)) ? 8'hff : 8'h00;
    end
    block_in = {block_first, block_second};
    if (mode == MODE_ABSORB) begin
      block_in = block_in & byte_keep;
    end
  end

  // One digit step: Z <- Z * x^DIGIT_BITS + digit * H, highest degree first.
  always_comb begin
    prod_shift[0] = prod;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      prod_shift[i+1] = times_x(prod_shift[i]);
    end
    prod_next = prod_shift[DIGIT_BITS];
    for (int k = 0; k < DIGIT_BITS; k++) begin
      if (operand[DIGIT_BITS-1-k]) begin
        prod_next = prod_next ^ key_pow[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      operand <= XP_W'(acc ^ block_in) << PAD;
      prod <= '0;
      item_finish <= mode;
      mask <= {mask_first, mask_second};
    end else if (cmd.step) begin
      operand <= operand >> DIGIT_BITS;
      prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.commit) begin
      acc <= prod_next;
    end else if (cmd.emit) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      {tag_first, tag_second} <= acc ^ mask;
    end
  end

  always_comb begin
    status.item_empty = (mode == MODE_ABSORB) && (byte_count == '0);
    status.finish = (item_finish == MODE_FINISH);
    status.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

[hdl/ghash_tag_accumulator.sv]
// Top level of the GHASH tag accumulator: controller and datapath joined.
//
//  Channel  Direction  Handshake              Carries
//  in       in         in_valid / in_ready    mode, block, byte_count, tag mask
//  out      out        out_valid / out_ready  tag_first, tag_second
//  cfg      in         cfg_write              hash key halves by cfg_index
//
// An item is taken in the idle state, then the multiply by H runs one digit of
// DIGIT_BITS coefficients per cycle, 128 / DIGIT_BITS digits rounded up in all
// (32 at the default of four), and the product is written back to the accumulator.
// A finish item adds an emit state in which the tag is loaded into the output
// register, and waits there if the previous tag has not yet been transferred.
// The shared digit-step multiplier sets the rate: one item at a time.
// Reset is synchronous and clears the hash key, the accumulator and the
// controller; an absorb item with a zero byte count is transferred and dropped.
`default_nettype none

module ghash_tag_accumulator
  import gta_pkg::*;
#(
  parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [REG_INDEX_W-1:0]  cfg_index,
  input  wire logic [HALF_BITS-1:0]    cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    mode,
  input  wire logic [HALF_BITS-1:0]    block_first,
  input  wire logic [HALF_BITS-1:0]    block_second,
  input  wire logic [BYTE_COUNT_W-1:0] byte_count,
  input  wire logic [HALF_BITS-1:0]    mask_first,
  input  wire logic [HALF_BITS-1:0]    mask_second,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [HALF_BITS-1:0]         tag_first,
  output logic [HALF_BITS-1:0]         tag_second
);

  // Digits per multiply; a digit width that does not divide 128 is padded
  // with zero coefficients above the top degree, which leaves the product alone.
  localparam int STEPS = (BLOCK_BITS + DIGIT_BITS - 1) / DIGIT_BITS;

  cmd_t cmd;
  status_t status;

  gta_ctrl #(
    .STEPS(STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gta_datapath #(
    .DIGIT_BITS(DIGIT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .block_first  (block_first),
    .block_second (block_second),
    .byte_count   (byte_count),
    .mask_first   (mask_first),
    .mask_second  (mask_second),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tag_first    (tag_first),
    .tag_second   (tag_second)
  );

endmodule

`default_nettype wire

[hdl/gta_checker.sv]
// Port-level checks for the GHASH tag accumulator and their binding.
`default_nettype none

module gta_checker
  import gta_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    mode,
  input wire logic [BYTE_COUNT_W-1:0] byte_count,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [HALF_BITS-1:0]    tag_first,
  input wire logic [HALF_BITS-1:0]    tag_second
);

  // A tag waiting for its transfer stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tag_first) && $stable(tag_second))
    else $error("tag changed or dropped before its transfer");

  // A real item keeps the input side closed while the multiply runs.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_FINISH || byte_count != '0) |=> !in_ready)
    else $error("input taken while an item is at work");

  // A new tag only appears after a finish item has been worked on.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("tag produced without an item at work");

  // Leaving reset the block is idle and holds no result.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind ghash_tag_accumulator gta_checker u_gta_checker (.*);

`default_nettype wire

[tb/sv/ghash_tag_monitor.sv]
// Channel monitor for the GHASH tag accumulator: predicts each tag and checks the output channel.
module ghash_tag_monitor
  import gta_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [REG_INDEX_W-1:0]  cfg_index,
  input  wire logic [HALF_BITS-1:0]    cfg_data,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic                    mode,
  input  wire logic [HALF_BITS-1:0]    block_first,
  input  wire logic [HALF_BITS-1:0]    block_second,
  input  wire logic [BYTE_COUNT_W-1:0] byte_count,
  input  wire logic [HALF_BITS-1:0]    mask_first,
  input  wire logic [HALF_BITS-1:0]    mask_second,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic [HALF_BITS-1:0]    tag_first,
  input  wire logic [HALF_BITS-1:0]    tag_second,
  output int                           fail_count,
  output int                           tags_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // x^128 + x^7 + x^2 + x + 1 folded back into the low-degree end (GCM bit order).
  localparam logic [127:0] FIELD_REDUCE = {8'he1, 120'd0};

  typedef struct packed {
    logic [HALF_BITS-1:0] first;
    logic [HALF_BITS-1:0] second;
  } tag_t;

  logic [127:0] hash_key = '0;
  logic [127:0] running_hash = '0;
  logic [127:0] product;
  tag_t         expected_tags[$];
  tag_t         seen;
  tag_t         want;

  // Plain bit-serial GF(2^128) product; bit 127 of a vector is the x^0 coefficient.
  function automatic logic [127:0] gf128_times(input logic [127:0] x, input logic [127:0] h);
    logic [127:0] z;
    logic [127:0] v;
    z = '0;
    v = h;
    for (int i = 127; i >= 0; i--) begin
      if (x[i]) begin
        z = z ^ v;
      end
      v = v[0] ? ((v >> 1) ^ FIELD_REDUCE) : (v >> 1);
    end
    return z;
  endfunction

  // Keeps the leading bytes of a block; counts above sixteen mean a full block.
  function automatic logic [127:0] leading_bytes(input logic [BYTE_COUNT_W-1:0] count);
    int n;
    n = (count > 16) ? 16 : int'(count);
    return ~128'd0 << (8 * (16 - n));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hash_key = '0;
      running_hash = '0;
      expected_tags.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_FIRST:  hash_key[127:64] = cfg_data;
          REG_KEY_SECOND: hash_key[63:0] = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        seen = {tag_first, tag_second};
        if (expected_tags.size() == 0) begin
          $error("tag %h %h transferred with no tag expected", seen.first, seen.second);
          fail_count++;
        end else begin
          want = expected_tags.pop_front();
          if (seen.first !== want.first) begin
            $error("tag_first: expected %h, got %h", want.first, seen.first);
            fail_count++;
          end
          if (seen.second !== want.second) begin
            $error("tag_second: expected %h, got %h", want.second, seen.second);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (mode == MODE_FINISH) begin
          product = gf128_times(running_hash ^ {block_first, block_second}, hash_key);
          expected_tags.push_back(tag_t'(product ^ {mask_first, mask_second}));
          running_hash = '0;
        end else if (byte_count != 0) begin
          running_hash = gf128_times(
              running_hash ^ ({block_first, block_second} & leading_bytes(byte_count)),
              hash_key);
        end
      end
    end
    tags_pending <= expected_tags.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the GHASH tag accumulator: clock, reset, stimulus and verdict.
module tb
  import gta_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The two upper register indexes are not mapped; writes there must leave H alone.
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LOW = 2'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

  // This is a comfortable margin over an absorb at four bits per step, for any item
  // that is still in the multiplier when the last tag has arrived.
  localparam int DRAIN_CYCLES = 64;

  // Behaviour of the tag receiver over one stretch of cycles.
  typedef enum int {
    RX_STEADY,
    RX_PATCHY,
    RX_STARVED
  } rx_style_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [REG_INDEX_W-1:0]  cfg_index = '0;
  logic [HALF_BITS-1:0]    cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    mode = MODE_ABSORB;
  logic [HALF_BITS-1:0]    block_first = '0;
  logic [HALF_BITS-1:0]    block_second = '0;
  logic [BYTE_COUNT_W-1:0] byte_count = '0;
  logic [HALF_BITS-1:0]    mask_first = '0;
  logic [HALF_BITS-1:0]    mask_second = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [HALF_BITS-1:0]    tag_first;
  logic [HALF_BITS-1:0]    tag_second;
  int                      fail_count;
  int                      tags_pending;

  // Sender burst bookkeeping: transfers left before the next gap.
  int        burst_left = 0;
  // Receiver pattern bookkeeping.
  rx_style_t rx_style = RX_STEADY;
  int        style_left = 0;

  ghash_tag_accumulator u_top (.*);

  // The monitor sits beside the block, sees the same wires and keeps its own
  // copy of H and of the running hash, so the top only has to drive stimulus.
  ghash_tag_monitor u_monitor (.*);

  always #5 clk = ~clk;

  // The receiver switches between being always ready, dithering at random and
  // being starved for long spells. Each style lasts long enough to cover many
  // items, so tags are held back at every point of the multiply as well as
  // being taken the moment they appear.
  always @(posedge clk) begin
    if (style_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 2));
      style_left = $urandom_range(40, 300);
    end
    style_left--;
    case (rx_style)
      RX_STEADY: out_ready <= 1'b1;
      RX_PATCHY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Watchdog. The slowest sound run is far below this; hitting it means a hang.
  initial begin
    #10_000_000;
    $display("ghash_tag_accumulator verification failed");
    $finish;
  end

  function automatic logic [HALF_BITS-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one item and returns just after the edge at which it transferred.
  // The sender runs in bursts: when a burst is used up it drops valid for a
  // random gap, which lands anywhere within the block's multiply, and then
  // starts a new burst, now and then a long one with no gaps at all.
  task automatic offer(input logic m, input logic [HALF_BITS-1:0] bf,
                       input logic [HALF_BITS-1:0] bs, input logic [BYTE_COUNT_W-1:0] bc,
                       input logic [HALF_BITS-1:0] mf, input logic [HALF_BITS-1:0] ms);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    mode <= m;
    block_first <= bf;
    block_second <= bs;
    byte_count <= bc;
    mask_first <= mf;
    mask_second <= ms;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Holds the sender back until every tag has been transferred, then lets the
  // block finish any absorb that produces no tag. The pending count is read only
  // after the monitor has registered the last transfer.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tags_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write on the configuration port; the caller lowers the enable after
  // the last write of a group so that back-to-back writes keep it high.
  task automatic cfg_poke(input logic [REG_INDEX_W-1:0] idx, input logic [HALF_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Loads a new hash key. The unmapped indexes are written in between with
  // random data, which must not disturb either half of H.
  task automatic set_key(input logic [HALF_BITS-1:0] k_first, input logic [HALF_BITS-1:0] k_second);
    cfg_poke(REG_KEY_FIRST, k_first);
    cfg_poke(REG_SPARE_LOW, random_word());
    cfg_poke(REG_KEY_SECOND, k_second);
    cfg_poke(REG_SPARE_HIGH, random_word());
    cfg_write <= 1'b0;
  endtask

  // Absorbs a run of blocks as a GCM section would: full blocks, with the
  // last one often short. The section length in bits is added to total_bits.
  task automatic absorb_section(input int blocks, inout longint unsigned total_bits);
    logic [BYTE_COUNT_W-1:0] bc;
    for (int j = 0; j < blocks; j++) begin
      bc = (j == blocks - 1 && $urandom_range(0, 1) == 1) ? 5'($urandom_range(1, 16)) : 5'd16;
      offer(MODE_ABSORB, random_word(), random_word(), bc, random_word(), random_word());
      total_bits += 8 * bc;
    end
  endtask

  // Random traffic. Most of it is complete messages (AAD blocks, ciphertext
  // blocks and a finish carrying the true bit lengths); the rest is noise:
  // empty absorbs, over-long byte counts and stray finishes with random lengths.
  task automatic run_messages(input int item_goal);
    int                sent;
    int                pick;
    int                n_aad;
    int                n_text;
    longint unsigned   aad_bits;
    longint unsigned   text_bits;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // Transferred and dropped by the block, so it is not counted.
        offer(MODE_ABSORB, random_word(), random_word(), 5'd0, random_word(), random_word());
      end else if (pick == 1) begin
        offer(MODE_ABSORB, random_word(), random_word(), 5'($urandom_range(17, 31)),
              random_word(), random_word());
        sent++;
      end else if (pick == 2) begin
        offer(MODE_FINISH, random_word(), random_word(), 5'($urandom_range(0, 31)),
              random_word(), random_word());
        sent++;
      end else begin
        n_aad = $urandom_range(0, 3);
        n_text = $urandom_range(0, 4);
        aad_bits = 0;
        text_bits = 0;
        absorb_section(n_aad, aad_bits);
        absorb_section(n_text, text_bits);
        offer(MODE_FINISH, aad_bits, text_bits, 5'($urandom_range(0, 31)),
              random_word(), random_word());
        sent += n_aad + n_text + 1;
      end
    end
  endtask

  initial begin
    int short_counts[5];
    short_counts = '{1, 7, 8, 9, 15};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight out of reset H is zero, so the hash is zero and the tag is
    // just the mask.
    offer(MODE_ABSORB, '1, '1, 5'd16, random_word(), random_word());
    offer(MODE_FINISH, 64'd0, 64'd128, 5'd16, random_word(), random_word());
    settle();

    // Directed items under a random key: all-zero and all-one blocks, every
    // interesting byte count, an empty absorb, counts above sixteen, finishes
    // with extreme lengths and masks, and a finish on an empty message.
    set_key(random_word(), random_word());
    offer(MODE_ABSORB, '0, '0, 5'd16, '1, '1);
    offer(MODE_ABSORB, '1, '1, 5'd16, '0, '0);
    foreach (short_counts[i]) begin
      offer(MODE_ABSORB, random_word(), random_word(), 5'(short_counts[i]),
            random_word(), random_word());
    end
    offer(MODE_ABSORB, random_word(), random_word(), 5'd0, random_word(), random_word());
    offer(MODE_ABSORB, random_word(), random_word(), 5'd31, random_word(), random_word());
    offer(MODE_ABSORB, '1, '1, 5'd17, random_word(), random_word());
    offer(MODE_FINISH, '1, '1, 5'd16, '1, '1);
    offer(MODE_FINISH, '0, '0, 5'd0, '0, '0);
    offer(MODE_FINISH, '0, '0, 5'd31, random_word(), random_word());
    settle();

    // Random phases, each under its own key and each ended by a full drain.
    set_key(random_word(), random_word());
    run_messages(200);
    settle();

    set_key('1, '1);
    run_messages(200);
    settle();

    // H = 1 makes the multiply the identity.
    set_key(64'h8000_0000_0000_0000, 64'd0);
    run_messages(200);
    settle();

    set_key('0, '0);
    run_messages(60);
    settle();

    // Only the first half is replaced: the table must be rebuilt around the
    // half that was kept.
    cfg_poke(REG_KEY_FIRST, random_word());
    cfg_write <= 1'b0;
    run_messages(200);
    settle();

    if (fail_count == 0 && tags_pending == 0) begin
      $display("ghash_tag_accumulator verification clean");
    end else begin
      $display("ghash_tag_accumulator verification failed");
    end
    $finish;
  end

endmodule
